FILE: hdl/srsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, codes and sizes for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int WinMax     = 32;
  localparam int SlotW      = $clog2(WinMax);
  localparam int CntW       = $clog2(WinMax + 1);
  localparam int SeqW       = 32;
  localparam int LenW       = 11;
  localparam int MaxPayload = 1461;
  localparam int WinReset   = 8;

  // request codes
  typedef enum logic [1:0] {
    REQ_OFFER   = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_FULL = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_IDLE = 2'd3
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFER,
    ST_MARK,
    ST_RELEASE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // one result word from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [SeqW-1:0]   seq;
    logic [SlotW-1:0]  slot;
    logic [LenW-1:0]   length;
    logic [CntW-1:0]   released;
    logic [CntW-1:0]   in_flight;
    logic              last;
  } result_t;

  // length memory access
  typedef struct packed {
    logic              we;
    logic [SlotW-1:0]  waddr;
    logic [LenW-1:0]   wdata;
    logic [SlotW-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: hdl/srsw_len_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_len_mem
// Segment length store, one entry per ring slot, registered read.
// ----------------------------------------------------------------------------
module srsw_len_mem (
  input  logic                       clk_i,
  input  srsw_pkg::mem_req_t         req_i,
  output logic [srsw_pkg::LenW-1:0]  rdata_o
);

  logic [srsw_pkg::LenW-1:0] mem [srsw_pkg::WinMax];
  logic [srsw_pkg::LenW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, data registered from the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/srsw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_ctrl
// Window state and sequencer. One shared ring-step unit advances the tail,
// the head and the timeout scan pointer.
// ----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config word
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [srsw_pkg::CntW-1:0]  cfg_window_i,
  // request word
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [srsw_pkg::LenW-1:0]  seg_length_i,
  input  logic [srsw_pkg::SeqW-1:0]  ack_seq_i,
  input  logic                       ack_good_i,
  // result word to output register
  input  logic                       out_free_i,
  output srsw_pkg::result_t          res_o,
  // length memory
  output srsw_pkg::mem_req_t         mem_o,
  input  logic [srsw_pkg::LenW-1:0]  mem_rdata_i
);

  localparam int SlotW = srsw_pkg::SlotW;
  localparam int CntW  = srsw_pkg::CntW;
  localparam int SeqW  = srsw_pkg::SeqW;
  localparam int LenW  = srsw_pkg::LenW;

  srsw_pkg::state_e state_q, state_d;

  logic [CntW-1:0]          win_q, win_d;
  logic [SeqW-1:0]          base_q, base_d;
  logic [SeqW-1:0]          next_q, next_d;
  logic [SlotW-1:0]         head_q, head_d;
  logic [SlotW-1:0]         tail_q, tail_d;
  logic [CntW-1:0]          occ_q, occ_d;
  logic [CntW-1:0]          unacked_q, unacked_d;
  logic [srsw_pkg::WinMax-1:0] acked_q, acked_d;
  logic [1:0]               req_q, req_d;
  logic [LenW-1:0]          len_q, len_d;
  logic [SeqW-1:0]          ack_seq_q, ack_seq_d;
  logic                     ack_good_q, ack_good_d;
  logic [CntW-1:0]          rel_q, rel_d;
  logic [SlotW-1:0]         scan_slot_q, scan_slot_d;
  logic [SeqW-1:0]          scan_seq_q, scan_seq_d;
  logic [CntW-1:0]          left_q, left_d;

  logic                     accept;
  logic [CntW-1:0]          cfg_win;
  logic [LenW-1:0]          len_sat;

  // clamp written window size to 1..WinMax
  always_comb begin
    if (cfg_window_i == '0) begin
      cfg_win = CntW'(1);
    end else if (cfg_window_i > CntW'(srsw_pkg::WinMax)) begin
      cfg_win = CntW'(srsw_pkg::WinMax);
    end else begin
      cfg_win = cfg_window_i;
    end
  end

  assign len_sat = (seg_length_i > LenW'(srsw_pkg::MaxPayload)) ?
                   LenW'(srsw_pkg::MaxPayload) : seg_length_i;

  // config has priority at idle
  assign cfg_ready_o = (state_q == srsw_pkg::ST_IDLE);
  assign in_ready_o  = (state_q == srsw_pkg::ST_IDLE) && !cfg_valid_i;
  assign accept      = in_valid_i && in_ready_o;

  // shared ring-step unit: slot + 1 modulo window
  logic [SlotW-1:0] ring_op, ring_nxt;
  logic [CntW-1:0]  ring_sum;

  always_comb begin
    unique case (state_q)
      srsw_pkg::ST_OFFER:   ring_op = tail_q;
      srsw_pkg::ST_RELEASE: ring_op = head_q;
      default:              ring_op = scan_slot_q;
    endcase
    ring_sum = {1'b0, ring_op} + CntW'(1);
    ring_nxt = (ring_sum == win_q) ? '0 : ring_sum[SlotW-1:0];
  end

  // ack position inside the window
  logic [SeqW-1:0]  ack_diff;
  logic             ack_in_win;
  logic [CntW:0]    mark_sum;
  logic [SlotW-1:0] mark_idx;

  always_comb begin
    ack_diff   = ack_seq_q - base_q;
    ack_in_win = ack_diff < {{(SeqW-CntW){1'b0}}, occ_q};
    mark_sum   = {2'b00, head_q} + {1'b0, ack_diff[CntW-1:0]};
    if (mark_sum >= {1'b0, win_q}) begin
      mark_sum = mark_sum - {1'b0, win_q};
    end
    mark_idx   = mark_sum[SlotW-1:0];
  end

  logic room;
  logic rel_step;
  assign room     = occ_q < win_q;
  assign rel_step = ack_good_q && (occ_q != '0) && acked_q[head_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (srsw_pkg::req_e'(req_type_i))
            srsw_pkg::REQ_OFFER:   state_d = srsw_pkg::ST_OFFER;
            srsw_pkg::REQ_ACK:     state_d = srsw_pkg::ST_MARK;
            srsw_pkg::REQ_TIMEOUT: state_d = srsw_pkg::ST_SCAN;
            default:               state_d = srsw_pkg::ST_IDLE;
          endcase
        end
      end
      srsw_pkg::ST_OFFER: begin
        if (out_free_i) state_d = srsw_pkg::ST_IDLE;
      end
      srsw_pkg::ST_MARK: begin
        state_d = srsw_pkg::ST_RELEASE;
      end
      srsw_pkg::ST_RELEASE: begin
        if (!rel_step && out_free_i) state_d = srsw_pkg::ST_IDLE;
      end
      srsw_pkg::ST_SCAN: begin
        if (left_q == '0) begin
          if (out_free_i) state_d = srsw_pkg::ST_IDLE;
        end else if (!acked_q[scan_slot_q]) begin
          state_d = srsw_pkg::ST_EMIT;
        end
      end
      srsw_pkg::ST_EMIT: begin
        if (out_free_i) begin
          state_d = (left_q == CntW'(1)) ? srsw_pkg::ST_IDLE : srsw_pkg::ST_SCAN;
        end
      end
      default: state_d = srsw_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    win_d       = win_q;
    base_d      = base_q;
    next_d      = next_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    unacked_d   = unacked_q;
    acked_d     = acked_q;
    req_d       = req_q;
    len_d       = len_q;
    ack_seq_d   = ack_seq_q;
    ack_good_d  = ack_good_q;
    rel_d       = rel_q;
    scan_slot_d = scan_slot_q;
    scan_seq_d  = scan_seq_q;
    left_d      = left_q;

    res_o       = '0;
    res_o.kind  = srsw_pkg::KIND_TX;
    mem_o       = '0;
    mem_o.raddr = scan_slot_q;

    unique case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (cfg_valid_i) begin
          // restart the window
          win_d     = cfg_win;
          base_d    = '0;
          next_d    = '0;
          head_d    = '0;
          tail_d    = SlotW'(cfg_win - CntW'(1));
          occ_d     = '0;
          unacked_d = '0;
          acked_d   = '0;
        end else if (accept) begin
          req_d       = req_type_i;
          len_d       = len_sat;
          ack_seq_d   = ack_seq_i;
          ack_good_d  = ack_good_i;
          rel_d       = '0;
          scan_slot_d = head_q;
          scan_seq_d  = base_q;
          left_d      = unacked_q;
        end
      end

      srsw_pkg::ST_OFFER: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.last  = 1'b1;
          if (room) begin
            tail_d              = ring_nxt;
            acked_d[ring_nxt]   = 1'b0;
            occ_d               = occ_q + CntW'(1);
            unacked_d           = unacked_q + CntW'(1);
            next_d              = next_q + SeqW'(1);
            mem_o.we            = 1'b1;
            mem_o.waddr         = ring_nxt;
            mem_o.wdata         = len_q;
            res_o.kind          = srsw_pkg::KIND_TX;
            res_o.seq           = next_q;
            res_o.slot          = ring_nxt;
            res_o.length        = len_q;
            res_o.in_flight     = occ_q + CntW'(1);
          end else begin
            res_o.kind      = srsw_pkg::KIND_FULL;
            res_o.in_flight = occ_q;
          end
        end
      end

      srsw_pkg::ST_MARK: begin
        if (ack_good_q && ack_in_win && !acked_q[mark_idx]) begin
          acked_d[mark_idx] = 1'b1;
          unacked_d         = unacked_q - CntW'(1);
        end
      end

      srsw_pkg::ST_RELEASE: begin
        if (rel_step) begin
          acked_d[head_q] = 1'b0;
          head_d          = ring_nxt;
          base_d          = base_q + SeqW'(1);
          occ_d           = occ_q - CntW'(1);
          rel_d           = rel_q + CntW'(1);
        end else if (out_free_i) begin
          res_o.valid     = 1'b1;
          res_o.last      = 1'b1;
          res_o.kind      = srsw_pkg::KIND_ACK;
          res_o.released  = rel_q;
          res_o.in_flight = occ_q;
        end
      end

      srsw_pkg::ST_SCAN: begin
        if (left_q == '0) begin
          if (out_free_i) begin
            res_o.valid     = 1'b1;
            res_o.last      = 1'b1;
            res_o.kind      = srsw_pkg::KIND_IDLE;
            res_o.in_flight = occ_q;
          end
        end else if (acked_q[scan_slot_q]) begin
          scan_slot_d = ring_nxt;
          scan_seq_d  = scan_seq_q + SeqW'(1);
        end
      end

      srsw_pkg::ST_EMIT: begin
        if (out_free_i) begin
          res_o.valid     = 1'b1;
          res_o.last      = (left_q == CntW'(1));
          res_o.kind      = srsw_pkg::KIND_TX;
          res_o.seq       = scan_seq_q;
          res_o.slot      = scan_slot_q;
          res_o.length    = mem_rdata_i;
          res_o.in_flight = occ_q;
          left_d          = left_q - CntW'(1);
          scan_slot_d     = ring_nxt;
          scan_seq_d      = scan_seq_q + SeqW'(1);
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srsw_pkg::ST_IDLE;
      win_q     <= CntW'(srsw_pkg::WinReset);
      base_q    <= '0;
      next_q    <= '0;
      head_q    <= '0;
      tail_q    <= SlotW'(srsw_pkg::WinReset - 1);
      occ_q     <= '0;
      unacked_q <= '0;
      acked_q   <= '0;
      left_q    <= '0;
      rel_q     <= '0;
    end else begin
      state_q   <= state_d;
      win_q     <= win_d;
      base_q    <= base_d;
      next_q    <= next_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      occ_q     <= occ_d;
      unacked_q <= unacked_d;
      acked_q   <= acked_d;
      left_q    <= left_d;
      rel_q     <= rel_d;
    end
  end

  // request payload and scan pointers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    len_q       <= len_d;
    ack_seq_q   <= ack_seq_d;
    ack_good_q  <= ack_good_d;
    scan_slot_q <= scan_slot_d;
    scan_seq_q  <= scan_seq_d;
  end

  // the latched request type must match the state on the offer path
  a_req_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srsw_pkg::ST_OFFER) |-> (req_q == srsw_pkg::REQ_OFFER))
    else $error("offer path entered for another request type");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= win_q)
    else $error("occupancy above window size");

  a_unacked_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unacked_q <= occ_q)
    else $error("unacked count above occupancy");

  a_emit_unacked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srsw_pkg::ST_EMIT) |-> !acked_q[scan_slot_q])
    else $error("resend of an acked slot");

endmodule

FILE: hdl/selective_repeat_sender_window.sv
`timescale 1ns / 1ps
// Flow: an offer passes through the offer state, a timeout with nothing
//   pending through the scan state, an ack through the mark and release states.
//   Each word then enters the output register. A new request is taken only in
//   the idle state, once the last word of the previous one is handed on. A resend
//   burst walks the in-flight slots in turn through the shared ring-step unit.
// Reset: window size 8, empty window, acked map cleared at once; no clearing
//   pass, length store contents undefined until written.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat transport: offers, acks and timeouts in,
// transmit commands and status words out through an output register.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config word
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [srsw_pkg::CntW-1:0]  window_size_i,
  // request word
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [srsw_pkg::LenW-1:0]  seg_length_i,
  input  logic [srsw_pkg::SeqW-1:0]  ack_seq_i,
  input  logic                       ack_good_i,
  // result word
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 out_kind_o,
  output logic [srsw_pkg::SeqW-1:0]  tx_seq_o,
  output logic [srsw_pkg::SlotW-1:0] tx_slot_o,
  output logic [srsw_pkg::LenW-1:0]  tx_length_o,
  output logic [srsw_pkg::CntW-1:0]  released_o,
  output logic [srsw_pkg::CntW-1:0]  in_flight_o,
  output logic                       last_o
);

  srsw_pkg::result_t          res;
  srsw_pkg::result_t          out_q;
  srsw_pkg::mem_req_t         mem_req;
  logic [srsw_pkg::LenW-1:0]  mem_rdata;
  logic                       out_valid_q;
  logic                       out_free;

  // output register can take a word when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  srsw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_window_i (window_size_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .seg_length_i (seg_length_i),
    .ack_seq_i    (ack_seq_i),
    .ack_good_i   (ack_good_i),
    .out_free_i   (out_free),
    .res_o        (res),
    .mem_o        (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  srsw_len_mem u_len_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_q.kind;
  assign tx_seq_o    = out_q.seq;
  assign tx_slot_o   = out_q.slot;
  assign tx_length_o = out_q.length;
  assign released_o  = out_q.released;
  assign in_flight_o = out_q.in_flight;
  assign last_o      = out_q.last;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective-repeat sender window. A request-level
// window tracker predicts every transmit and status word from the accepted
// requests. Directed corner cases run first, then random offers, acks and
// timeouts under several window sizes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 400000;

  localparam int SeqW       = srsw_pkg::SeqW;
  localparam int SlotW      = srsw_pkg::SlotW;
  localparam int LenW       = srsw_pkg::LenW;
  localparam int CntW       = srsw_pkg::CntW;
  localparam int WinMax     = srsw_pkg::WinMax;
  localparam int WinReset   = srsw_pkg::WinReset;
  localparam int MaxPayload = srsw_pkg::MaxPayload;

  // one expected output word
  typedef struct {
    srsw_pkg::kind_e   kind;
    logic [SeqW-1:0]   seq;
    logic [SlotW-1:0]  slot;
    logic [LenW-1:0]   length;
    logic [CntW-1:0]   released;
    logic [CntW-1:0]   in_flight;
    logic              last;
  } status_word_t;

  // window state tracker and queue of expected words
  class window_tracker;
    int unsigned     win;
    logic [LenW-1:0] slot_len [WinMax];
    bit              slot_done [WinMax];
    logic [SeqW-1:0] base_seq;
    logic [SeqW-1:0] next_seq;
    int unsigned     head;
    int unsigned     tail;
    int unsigned     occ;
    status_word_t    expected_words[$];
    int unsigned     errors;

    function new();
      errors = 0;
      resize(WinReset);
    endfunction

    // new size also restarts the window
    function void resize(int unsigned size);
      win = (size < 1) ? 1 : ((size > WinMax) ? WinMax : size);
      foreach (slot_done[i]) slot_done[i] = 1'b0;
      base_seq = '0;
      next_seq = '0;
      head     = 0;
      tail     = win - 1;
      occ      = 0;
    endfunction

    function void add_word(srsw_pkg::kind_e kind, logic [SeqW-1:0] seq,
                           int unsigned slot, logic [LenW-1:0] len,
                           int unsigned rel, bit fin);
      status_word_t w;
      w.kind      = kind;
      w.seq       = seq;
      w.slot      = SlotW'(slot);
      w.length    = len;
      w.released  = CntW'(rel);
      w.in_flight = CntW'(occ);
      w.last      = fin;
      expected_words.push_back(w);
    endfunction

    function void note_request(srsw_pkg::req_e req, logic [LenW-1:0] len,
                               logic [SeqW-1:0] seq, logic good);
      logic [LenW-1:0] clip;
      logic [SeqW-1:0] offset;
      int unsigned     rel;
      int unsigned     pending;
      int unsigned     sent;
      int unsigned     s;
      case (req)
        srsw_pkg::REQ_OFFER: begin
          clip = (len > MaxPayload) ? LenW'(MaxPayload) : len;
          if (occ < win) begin
            tail = (tail + 1) % win;
            slot_len[tail]  = clip;
            slot_done[tail] = 1'b0;
            occ++;
            add_word(srsw_pkg::KIND_TX, next_seq, tail, clip, 0, 1'b1);
            next_seq++;
          end else begin
            add_word(srsw_pkg::KIND_FULL, '0, 0, '0, 0, 1'b1);
          end
        end
        srsw_pkg::REQ_ACK: begin
          rel = 0;
          if (good) begin
            // modular distance from the window base
            offset = seq - base_seq;
            if (offset < occ) slot_done[(head + offset) % win] = 1'b1;
            while (occ > 0 && slot_done[head]) begin
              slot_done[head] = 1'b0;
              head = (head + 1) % win;
              base_seq++;
              occ--;
              rel++;
            end
          end
          add_word(srsw_pkg::KIND_ACK, '0, 0, '0, rel, 1'b1);
        end
        srsw_pkg::REQ_TIMEOUT: begin
          pending = 0;
          for (int j = 0; j < occ; j++)
            if (!slot_done[(head + j) % win]) pending++;
          if (pending == 0) begin
            add_word(srsw_pkg::KIND_IDLE, '0, 0, '0, 0, 1'b1);
          end else begin
            sent = 0;
            for (int j = 0; j < occ; j++) begin
              s = (head + j) % win;
              if (!slot_done[s]) begin
                sent++;
                add_word(srsw_pkg::KIND_TX, base_seq + j, s, slot_len[s], 0,
                         sent == pending);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_word(logic [1:0] kind, logic [SeqW-1:0] seq, logic [SlotW-1:0] slot,
                    logic [LenW-1:0] len, logic [CntW-1:0] rel,
                    logic [CntW-1:0] fl, logic fin);
      status_word_t exp;
      string        bad;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d seq %0d", kind, seq));
        return;
      end
      exp = expected_words.pop_front();
      bad = "";
      if (kind !== exp.kind)     bad = {bad, " kind"};
      if (seq !== exp.seq)       bad = {bad, " tx_seq"};
      if (slot !== exp.slot)     bad = {bad, " tx_slot"};
      if (len !== exp.length)    bad = {bad, " tx_length"};
      if (rel !== exp.released)  bad = {bad, " released"};
      if (fl !== exp.in_flight)  bad = {bad, " in_flight"};
      if (fin !== exp.last)      bad = {bad, " last"};
      if (bad != "")
        report($sformatf({"bad%s: got k%0d s%0d sl%0d l%0d r%0d f%0d e%0d,",
                          " exp k%0d s%0d sl%0d l%0d r%0d f%0d e%0d"},
                         bad, kind, seq, slot, len, rel, fl, fin,
                         exp.kind, exp.seq, exp.slot, exp.length,
                         exp.released, exp.in_flight, exp.last));
    endtask
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CntW-1:0]      window_size_i = CntW'(WinReset);
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           req_type_i    = srsw_pkg::REQ_NONE;
  logic [LenW-1:0]      seg_length_i  = '0;
  logic [SeqW-1:0]      ack_seq_i     = '0;
  logic                 ack_good_i    = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [1:0]           out_kind_o;
  logic [SeqW-1:0]      tx_seq_o;
  logic [SlotW-1:0]     tx_slot_o;
  logic [LenW-1:0]      tx_length_o;
  logic [CntW-1:0]      released_o;
  logic [CntW-1:0]      in_flight_o;
  logic                 last_o;

  window_tracker tracker;
  bit            calm = 1'b0;  // no stalls on either side while set
  int unsigned   cycles = 0;

  selective_repeat_sender_window uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .window_size_i (window_size_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .seg_length_i  (seg_length_i),
    .ack_seq_i     (ack_seq_i),
    .ack_good_i    (ack_good_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_kind_o    (out_kind_o),
    .tx_seq_o      (tx_seq_o),
    .tx_slot_o     (tx_slot_o),
    .tx_length_o   (tx_length_o),
    .released_o    (released_o),
    .in_flight_o   (in_flight_o),
    .last_o        (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random backpressure
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 16);
  end

  // check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_word(out_kind_o, tx_seq_o, tx_slot_o, tx_length_o,
                         released_o, in_flight_o, last_o);
  end

  // send one request word, note it on acceptance, maybe idle afterwards
  task automatic push_request(srsw_pkg::req_e req, logic [LenW-1:0] len,
                              logic [SeqW-1:0] seq, logic good);
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    seg_length_i <= len;
    ack_seq_i    <= seq;
    ack_good_i   <= good;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(req, len, seq, good);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // hold off until every expected word is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_window(logic [CntW-1:0] size);
    drain();
    cfg_valid_i   <= 1'b1;
    window_size_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.resize(size);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed traffic: offers, timeouts and in-window acks, some noise
  task automatic run_random(int unsigned count);
    int unsigned     done;
    int unsigned     roll;
    logic [LenW-1:0] len;
    logic [SeqW-1:0] seq;
    logic            good;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? LenW'($urandom) :
                                        LenW'($urandom_range(MaxPayload, 1));
      seq  = $urandom;
      good = ($urandom_range(9) != 0);
      if (roll < 45) begin
        push_request(srsw_pkg::REQ_OFFER, len, seq, good);
        done++;
      end else if (roll < 82) begin
        if ($urandom_range(4) != 0) seq = tracker.base_seq + $urandom_range(tracker.occ);
        push_request(srsw_pkg::REQ_ACK, len, seq, good);
        done++;
      end else if (roll < 96) begin
        push_request(srsw_pkg::REQ_TIMEOUT, len, seq, good);
        done++;
      end else begin
        push_request(srsw_pkg::REQ_NONE, len, seq, good);
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset window of 8
    push_request(srsw_pkg::REQ_TIMEOUT, '0, '0, 1'b0);       // nothing pending
    push_request(srsw_pkg::REQ_ACK, '0, '0, 1'b1);           // ack on empty window
    push_request(srsw_pkg::REQ_NONE, '1, '1, 1'b1);          // ignored
    push_request(srsw_pkg::REQ_OFFER, 11'd0, '0, 1'b0);      // empty segment
    push_request(srsw_pkg::REQ_OFFER, 11'd1, '0, 1'b0);
    push_request(srsw_pkg::REQ_OFFER, 11'd1461, '0, 1'b0);
    push_request(srsw_pkg::REQ_OFFER, 11'd1462, '0, 1'b0);   // saturates
    push_request(srsw_pkg::REQ_OFFER, 11'd2047, '1, 1'b1);   // saturates
    push_request(srsw_pkg::REQ_OFFER, 11'd700, '0, 1'b0);
    push_request(srsw_pkg::REQ_OFFER, 11'd1024, '0, 1'b0);
    push_request(srsw_pkg::REQ_OFFER, 11'd5, '0, 1'b0);
    push_request(srsw_pkg::REQ_OFFER, 11'd9, '0, 1'b0);      // window full
    push_request(srsw_pkg::REQ_TIMEOUT, '0, '0, 1'b0);       // full resend burst
    push_request(srsw_pkg::REQ_ACK, '0, 32'd2, 1'b1);        // out of order
    push_request(srsw_pkg::REQ_ACK, '0, 32'd0, 1'b1);        // head release
    push_request(srsw_pkg::REQ_ACK, '0, 32'd1, 1'b0);        // bad checksum
    push_request(srsw_pkg::REQ_ACK, '0, 32'hFFFF_FFFF, 1'b1);  // far outside
    push_request(srsw_pkg::REQ_ACK, '0, 32'd8, 1'b1);        // just past the window
    push_request(srsw_pkg::REQ_TIMEOUT, '0, '0, 1'b0);       // skips acked slot
    push_request(srsw_pkg::REQ_ACK, '0, 32'd1, 1'b1);        // releases two
    push_request(srsw_pkg::REQ_OFFER, 11'd300, '0, 1'b0);    // ring wraps
    push_request(srsw_pkg::REQ_ACK, '0, 32'd2, 1'b1);        // already released
    push_request(srsw_pkg::REQ_TIMEOUT, '0, '0, 1'b0);
    run_random(25);

    // smallest window
    write_window(CntW'(1));
    run_random(20);

    // largest window, no stalls, with a full drain midway
    write_window(CntW'(32));
    calm = 1'b1;
    run_random(15);
    drain();
    run_random(15);
    calm = 1'b0;

    // out-of-range sizes clamp
    write_window(CntW'(0));
    run_random(15);
    write_window(CntW'(63));
    run_random(25);
    write_window(CntW'(5));
    run_random(20);

    drain();
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/srsw_pkg.sv
hdl/srsw_len_mem.sv
hdl/srsw_ctrl.sv
hdl/selective_repeat_sender_window.sv
bench/tb.sv
